@@ hw/rtl/imbs_pkg.sv @@
// shared types and constants for the incidence matrix boolean search block
package imbs_pkg;

    localparam int CMD_W   = 1;
    localparam int TERM_W  = 8;
    localparam int DOC_W   = 6;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_SET   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    localparam logic [COUNT_W-1:0] DOC_COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic start_emit;
        logic out_free;
        logic final_result;
    } ctrl_sts_t;

endpackage

@@ hw/rtl/imbs_if.sv @@
// valid/ready channel interfaces for input items and result items
interface imbs_item_if;
    logic                        valid;
    logic                        ready;
    logic [imbs_pkg::CMD_W-1:0]  cmd;
    logic [imbs_pkg::TERM_W-1:0] term_index;
    logic [imbs_pkg::DOC_W-1:0]  doc_number;
    logic                        term_known;
    logic                        first_term;
    logic                        last_term;

    modport source (output valid, cmd, term_index, doc_number, term_known, first_term,
                    last_term, input ready);
    modport sink (input valid, cmd, term_index, doc_number, term_known, first_term,
                  last_term, output ready);
endinterface

interface imbs_result_if;
    logic                       valid;
    logic                       ready;
    logic [imbs_pkg::DOC_W-1:0] match_doc;
    logic                       found;
    logic                       last;

    modport source (output valid, match_doc, found, last, input ready);
    modport sink (input valid, match_doc, found, last, output ready);
endinterface

@@ hw/rtl/imbs_ctrl.sv @@
// controller state machine: clearing pass, item execution, result list
module imbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  imbs_pkg::ctrl_sts_t sts,
    output imbs_pkg::ctrl_cmd_t cmd
);
    import imbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.start_emit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.final_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/imbs_dpath.sv @@
// datapath: term row memory, running document mask, result scan and output register
module imbs_dpath #(
    parameter int TERM_COUNT = 256,
    parameter int DOC_MAX    = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  imbs_pkg::ctrl_cmd_t          cmd,
    output imbs_pkg::ctrl_sts_t          sts,
    input  logic [imbs_pkg::CMD_W-1:0]   in_cmd,
    input  logic [imbs_pkg::TERM_W-1:0]  in_term_index,
    input  logic [imbs_pkg::DOC_W-1:0]   in_doc_number,
    input  logic                         in_term_known,
    input  logic                         in_first_term,
    input  logic                         in_last_term,
    input  logic                         cfg_we,
    input  logic [imbs_pkg::COUNT_W-1:0] cfg_wdata,
    imbs_result_if.source                results
);
    import imbs_pkg::*;

    localparam int AW    = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;
    localparam int EXT_W = (AW > TERM_W) ? AW : TERM_W;

    // term row memory
    logic [DOC_MAX-1:0] mem [TERM_COUNT];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DOC_MAX-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [DOC_MAX-1:0] row_reg;

    logic [EXT_W-1:0]   term_ext;
    logic               term_ok;
    logic               doc_ok;

    // item registers
    logic [CMD_W-1:0]   cmd_reg;
    logic [AW-1:0]      addr_reg;
    logic               term_ok_reg;
    logic               doc_ok_reg;
    logic [DOC_W-1:0]   doc_reg;
    logic               known_reg;
    logic               first_reg;
    logic               last_reg;

    logic [AW-1:0]      clr_cnt_reg;
    logic [COUNT_W-1:0] doc_count_reg;
    logic [DOC_MAX-1:0] mask_reg;
    logic               failed_reg;
    logic [DOC_MAX-1:0] hits_reg;
    logic [DOC_MAX-1:0] limit_mask;
    logic [DOC_MAX-1:0] set_bit;
    logic [DOC_MAX-1:0] mask_base;
    logic               fail_base;
    logic [DOC_MAX-1:0] mask_new;
    logic               fail_new;
    logic [DOC_MAX-1:0] low_bit;
    logic [DOC_MAX-1:0] hits_rest;
    logic [DOC_W-1:0]   low_idx;

    logic               out_valid_reg;
    logic [DOC_W-1:0]   out_doc_reg;
    logic               out_found_reg;
    logic               out_last_reg;

    assign term_ext = EXT_W'(in_term_index);
    assign term_ok  = (32'(in_term_index) < 32'(TERM_COUNT));
    assign doc_ok   = (32'(in_doc_number) < 32'(DOC_MAX));

    always_comb
    begin
        for (int i = 0; i < DOC_MAX; i++)
        begin
            set_bit[i]    = (doc_reg == DOC_W'(i));
            limit_mask[i] = (COUNT_W'(i) < doc_count_reg);
        end
    end

    assign mem_raddr = term_ext[AW-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = row_reg | set_bit;
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.exec && cmd_reg == CMD_SET && term_ok_reg && doc_ok_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.load)
        begin
            row_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= in_cmd;
            addr_reg    <= term_ext[AW-1:0];
            term_ok_reg <= term_ok;
            doc_ok_reg  <= doc_ok;
            doc_reg     <= in_doc_number;
            known_reg   <= in_term_known;
            first_reg   <= in_first_term;
            last_reg    <= in_last_term;
        end
    end

    // query term: restart, then and in the row or mark the query failed
    always_comb
    begin
        mask_base = first_reg ? '1 : mask_reg;
        fail_base = first_reg ? 1'b0 : failed_reg;
        if (!known_reg || !term_ok_reg)
        begin
            fail_new = 1'b1;
            mask_new = mask_base;
        end
        else
        begin
            fail_new = fail_base;
            mask_new = mask_base & row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            doc_count_reg <= DOC_COUNT_RESET;
            mask_reg      <= '1;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_we)
            begin
                doc_count_reg <= cfg_wdata;
            end
            if (cmd.exec && cmd_reg == CMD_QUERY)
            begin
                if (last_reg)
                begin
                    mask_reg   <= '1;
                    failed_reg <= 1'b0;
                end
                else
                begin
                    mask_reg   <= mask_new;
                    failed_reg <= fail_new;
                end
            end
        end
    end

    // lowest remaining hit
    assign low_bit   = hits_reg & (~hits_reg + DOC_MAX'(1));
    assign hits_rest = hits_reg & ~low_bit;

    always_comb
    begin
        low_idx = '0;
        for (int i = DOC_MAX - 1; i >= 0; i--)
        begin
            if (hits_reg[i])
            begin
                low_idx = DOC_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && cmd_reg == CMD_QUERY && last_reg)
        begin
            hits_reg <= fail_new ? '0 : (mask_new & limit_mask);
        end
        else if (cmd.emit)
        begin
            hits_reg <= hits_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_doc_reg   <= low_idx;
            out_found_reg <= (hits_reg != '0);
            out_last_reg  <= (hits_rest == '0);
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.match_doc = out_doc_reg;
    assign results.found     = out_found_reg;
    assign results.last      = out_last_reg;

    assign sts.clear_done   = (clr_cnt_reg == AW'(TERM_COUNT - 1));
    assign sts.start_emit   = (cmd_reg == CMD_QUERY) && last_reg;
    assign sts.out_free     = !out_valid_reg || results.ready;
    assign sts.final_result = (hits_rest == '0);

endmodule

@@ hw/rtl/incidence_matrix_boolean_search_top.sv @@
// top level of the term-document incidence matrix with boolean and queries
//
//  channel  | dir | transfer carries
//  ---------+-----+---------------------------------------------------------------
//  items    | in  | cmd, term_index, doc_number, term_known, first_term, last_term
//  results  | out | match_doc, found, last
//  cfg      | in  | document_count, written when cfg_we is high
//
// every set item and query term first reads the term row from the row memory,
// then updates the row or the running document mask
// the last term of a query then streams the answer at one result per cycle
// reset starts a clearing pass over every row of the row memory with
// items held off; stalls on results hold the scan, the output register lets
// the next item transfer while the final result still waits
module incidence_matrix_boolean_search_top #(
    parameter int TERM_COUNT = 256,
    parameter int DOC_MAX    = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    imbs_item_if.sink                    items,
    imbs_result_if.source                results,
    input  logic                         cfg_we,
    input  logic [imbs_pkg::COUNT_W-1:0] cfg_wdata
);
    import imbs_pkg::*;

    // command and status between controller and datapath
    ctrl_cmd_t ctrl_cmd;
    ctrl_sts_t ctrl_sts;

    // sequencing: clear pass, then accept / execute / emit
    imbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .sts      (ctrl_sts),
        .cmd      (ctrl_cmd)
    );

    // row memory, mask and failure flag, hit scan and output register
    imbs_dpath #(
        .TERM_COUNT (TERM_COUNT),
        .DOC_MAX    (DOC_MAX)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctrl_cmd),
        .sts           (ctrl_sts),
        .in_cmd        (items.cmd),
        .in_term_index (items.term_index),
        .in_doc_number (items.doc_number),
        .in_term_known (items.term_known),
        .in_first_term (items.first_term),
        .in_last_term  (items.last_term),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .results       (results)
    );

endmodule

@@ tb/tb_incidence_matrix_boolean_search_top.sv @@
// self-checking testbench for the incidence matrix boolean search top level
`timescale 1ns / 100ps

module tb_incidence_matrix_boolean_search_top;
    import imbs_pkg::*;

    // ---------------------------------------------------------------------
    // run limits
    // ---------------------------------------------------------------------
    localparam int CYCLE_LIMIT   = 1_000_000;  // hard stop, far above the slowest pass
    localparam int SETTLE_CYCLES = 8;          // a set item or inner query term may still run
    localparam int TAIL_CYCLES   = 20;         // quiet time after the last result
    localparam int DRAIN_LIMIT   = 200_000;    // bound on the final wait for results
    localparam int HOLD_CYCLES   = 300;        // long receiver hold-off for back-pressure
    localparam int PHASE_ITEMS   = 43;         // random items per phase

    // one input item and one result item, at the block's widths
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TERM_W-1:0] term_index;
        logic [DOC_W-1:0]  doc_number;
        logic              term_known;
        logic              first_term;
        logic              last_term;
    } item_t;

    typedef struct packed {
        logic [DOC_W-1:0] doc;
        logic             found;
        logic             last;
    } answer_t;

    // directed row: the item, and a typed answer where it is obvious by eye
    typedef struct packed {
        item_t   it;
        logic    typed;
        answer_t ans;
    } directed_row_t;

    localparam answer_t NONE_FOUND = '{6'd0, 1'b0, 1'b1};
    localparam answer_t NO_ANSWER  = '{6'd0, 1'b0, 1'b0};

    // ---------------------------------------------------------------------
    // directed table
    // fields: cmd, term, doc, known, first, last | typed | doc, found, last
    // ---------------------------------------------------------------------
    localparam int DIRECTED_ROWS = 18;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty matrix straight after reset: nothing can match
        '{'{CMD_QUERY, 8'd0,   6'd0,  1'b1, 1'b1, 1'b1}, 1'b1, NONE_FOUND},
        // extreme corners of the matrix
        '{'{CMD_SET,   8'd255, 6'd63, 1'b0, 1'b0, 1'b0}, 1'b0, NO_ANSWER},
        '{'{CMD_SET,   8'd255, 6'd0,  1'b0, 1'b0, 1'b0}, 1'b0, NO_ANSWER},
        '{'{CMD_SET,   8'd0,   6'd0,  1'b0, 1'b0, 1'b0}, 1'b0, NO_ANSWER},
        // one-term query listing two documents
        '{'{CMD_QUERY, 8'd255, 6'd17, 1'b1, 1'b1, 1'b1}, 1'b0, NO_ANSWER},
        // two-term and: only document 0 holds both
        '{'{CMD_QUERY, 8'd0,   6'd0,  1'b1, 1'b1, 1'b0}, 1'b0, NO_ANSWER},
        '{'{CMD_QUERY, 8'd255, 6'd0,  1'b1, 1'b0, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b1}},
        // unknown one-term query
        '{'{CMD_QUERY, 8'd255, 6'd0,  1'b0, 1'b1, 1'b1}, 1'b1, NONE_FOUND},
        // unknown term in the middle cannot be revived by a later known term
        '{'{CMD_QUERY, 8'd0,   6'd0,  1'b1, 1'b1, 1'b0}, 1'b0, NO_ANSWER},
        '{'{CMD_QUERY, 8'd9,   6'd0,  1'b0, 1'b0, 1'b0}, 1'b0, NO_ANSWER},
        '{'{CMD_QUERY, 8'd255, 6'd0,  1'b1, 1'b0, 1'b1}, 1'b1, NONE_FOUND},
        // fresh query after the last term, no first_term needed
        '{'{CMD_QUERY, 8'd0,   6'd0,  1'b1, 1'b0, 1'b1}, 1'b0, NO_ANSWER},
        // query flags on a set item are ignored
        '{'{CMD_SET,   8'd1,   6'd5,  1'b1, 1'b1, 1'b1}, 1'b0, NO_ANSWER},
        '{'{CMD_QUERY, 8'd1,   6'd0,  1'b1, 1'b1, 1'b1}, 1'b1, '{6'd5, 1'b1, 1'b1}},
        // disjoint rows give an empty answer
        '{'{CMD_QUERY, 8'd255, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, NO_ANSWER},
        '{'{CMD_QUERY, 8'd1,   6'd0,  1'b1, 1'b0, 1'b1}, 1'b1, NONE_FOUND},
        // highest document number alone
        '{'{CMD_SET,   8'd200, 6'd63, 1'b0, 1'b0, 1'b0}, 1'b0, NO_ANSWER},
        '{'{CMD_QUERY, 8'd200, 6'd42, 1'b1, 1'b1, 1'b1}, 1'b1, '{6'd63, 1'b1, 1'b1}}
    };

    // ---------------------------------------------------------------------
    // clock, reset and channels
    // ---------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    imbs_item_if   item_ch ();
    imbs_result_if result_ch ();

    incidence_matrix_boolean_search_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // predictor state: own copy of the matrix, the running mask and the
    // document count
    // ---------------------------------------------------------------------
    logic [63:0]        term_rows_m [256];
    logic [63:0]        doc_mask_m;
    logic               query_failed_m;
    logic [COUNT_W-1:0] doc_count_m;

    answer_t answers_due[$];     // results still owed by the block, oldest first
    answer_t want;
    int      mismatch_count;
    int      cycle_count;
    int      send_idle_pct;      // chance in a hundred of a sender idle cycle
    int      recv_stall_pct;     // chance in a hundred of a receiver stall cycle
    bit      hold_request;       // asks the receiver for a long hold-off

    // works out the answers one accepted item causes, updating the copy state
    function automatic void work_out_answers(input item_t it, output answer_t produced[$]);
        logic [COUNT_W-1:0] limit;
        logic [63:0]        hits;
        answer_t            a;
        produced = {};
        if (it.cmd == CMD_SET)
        begin
            term_rows_m[it.term_index][it.doc_number] = 1'b1;
            return;
        end
        if (it.first_term)
        begin
            doc_mask_m     = '1;
            query_failed_m = 1'b0;
        end
        if (!it.term_known)
            query_failed_m = 1'b1;
        else
            doc_mask_m &= term_rows_m[it.term_index];
        if (!it.last_term)
            return;
        // counts above 64 act as 64
        limit = (doc_count_m > 7'd64) ? 7'd64 : doc_count_m;
        hits  = query_failed_m ? 64'd0 : doc_mask_m;
        for (int i = 0; i < 64; i++)
        begin
            if (i < limit && hits[i])
            begin
                a.doc   = DOC_W'(i);
                a.found = 1'b1;
                a.last  = 1'b0;
                produced.push_back(a);
            end
        end
        if (produced.size() == 0)
            produced.push_back(NONE_FOUND);
        else
            produced[$].last = 1'b1;
        // the query always ends clean
        doc_mask_m     = '1;
        query_failed_m = 1'b0;
    endfunction

    // ---------------------------------------------------------------------
    // item sender: offer the item, wait for the transfer, book the answers,
    // then idle at random
    // ---------------------------------------------------------------------
    task automatic send_item(input item_t it, input logic typed, input answer_t typed_ans);
        answer_t fresh[$];
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= it.cmd;
        item_ch.term_index <= it.term_index;
        item_ch.doc_number <= it.doc_number;
        item_ch.term_known <= it.term_known;
        item_ch.first_term <= it.first_term;
        item_ch.last_term  <= it.last_term;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        // predictor always runs so its state follows the block
        work_out_answers(it, fresh);
        if (typed)
        begin
            // typed rows only ever carry a query's last term with one answer
            answers_due.push_back(typed_ans);
        end
        else
        begin
            foreach (fresh[i])
                answers_due.push_back(fresh[i]);
        end
        // geometric idle gap; valid lowered only when a gap really follows
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // sender pauses until every owed result has come back
    task automatic wait_for_answers();
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    // register write only with the block idle
    task automatic write_doc_count(input logic [COUNT_W-1:0] value);
        item_ch.valid <= 1'b0;
        wait_for_answers();
        // a set item or inner query term leaves no result to wait on
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        doc_count_m  = value;
    endtask

    // ---------------------------------------------------------------------
    // one random phase: a document count, an idling mix, mostly well-formed
    // queries over a small pool of terms so that rows overlap, with set
    // bursts to fill them and some noise items with every field random
    // ---------------------------------------------------------------------
    task automatic run_phase(input logic [COUNT_W-1:0] count, input int send_pct,
                             input int recv_pct, input int quota, input bit pressure);
        logic [TERM_W-1:0] pool [4];
        item_t             it;
        int                sent;
        int                pick;
        int                burst;
        int                n_terms;
        write_doc_count(count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        foreach (pool[i])
            pool[i] = TERM_W'($urandom_range(255));

        if (pressure)
        begin
            // fill one row densely, then hold the results back while the
            // sender keeps offering long answer lists
            repeat (24)
            begin
                it = '{CMD_SET, pool[0], DOC_W'($urandom_range(63)), 1'b0, 1'b0, 1'b0};
                send_item(it, 1'b0, NO_ANSWER);
            end
            hold_request = 1'b1;
            repeat (16)
            begin
                it = '{CMD_QUERY, pool[0], DOC_W'($urandom_range(63)), 1'b1, 1'b1, 1'b1};
                send_item(it, 1'b0, NO_ANSWER);
            end
            sent += 40;
            item_ch.valid <= 1'b0;
            wait_for_answers();
        end

        while (sent < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                // set burst, documents bunched low so rows share columns
                burst = $urandom_range(2, 6);
                repeat (burst)
                begin
                    it.cmd        = CMD_SET;
                    it.term_index = pool[$urandom_range(3)];
                    it.doc_number = ($urandom_range(1) != 0) ? DOC_W'($urandom_range(7))
                                                             : DOC_W'($urandom_range(63));
                    it.term_known = 1'($urandom_range(1));
                    it.first_term = 1'($urandom_range(1));
                    it.last_term  = 1'($urandom_range(1));
                    send_item(it, 1'b0, NO_ANSWER);
                    sent++;
                end
            end
            else if (pick < 85)
            begin
                // well-formed query, now and then without first_term
                n_terms = $urandom_range(1, 4);
                for (int k = 0; k < n_terms; k++)
                begin
                    it.cmd        = CMD_QUERY;
                    it.term_index = pool[$urandom_range(3)];
                    it.doc_number = DOC_W'($urandom_range(63));
                    it.term_known = ($urandom_range(19) != 0);
                    it.first_term = (k == 0) && ($urandom_range(7) != 0);
                    it.last_term  = (k == n_terms - 1);
                    send_item(it, 1'b0, NO_ANSWER);
                    sent++;
                end
            end
            else
            begin
                // noise: any field value, broken or abandoned queries
                it.cmd        = CMD_W'($urandom_range(1));
                it.term_index = TERM_W'($urandom_range(255));
                it.doc_number = DOC_W'($urandom_range(63));
                it.term_known = 1'($urandom_range(1));
                it.first_term = 1'($urandom_range(1));
                it.last_term  = 1'($urandom_range(1));
                send_item(it, 1'b0, NO_ANSWER);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // result receiver: random stalls, and a long hold-off on request,
    // counted here in its own process
    // ---------------------------------------------------------------------
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // result checker: every transfer against the oldest owed answer
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result with nothing owed: match_doc %0d found %0b last %0b",
                       result_ch.match_doc, result_ch.found, result_ch.last);
                mismatch_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (result_ch.match_doc !== want.doc)
                begin
                    $error("match_doc: expected %0d, actual %0d", want.doc, result_ch.match_doc);
                    mismatch_count++;
                end
                if (result_ch.found !== want.found)
                begin
                    $error("found: expected %0b, actual %0b", want.found, result_ch.found);
                    mismatch_count++;
                end
                if (result_ch.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, result_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        int drain_wait;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;

        foreach (term_rows_m[t])
            term_rows_m[t] = '0;
        doc_mask_m     = '1;
        query_failed_m = 1'b0;
        doc_count_m    = DOC_COUNT_RESET;

        // every input known from time zero
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.cmd        <= CMD_SET;
        item_ch.term_index <= '0;
        item_ch.doc_number <= '0;
        item_ch.term_known <= 1'b0;
        item_ch.first_term <= 1'b0;
        item_ch.last_term  <= 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset document count; the clearing pass
        // after reset simply holds off the first transfer
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(DIRECTED[r].it, DIRECTED[r].typed, DIRECTED[r].ans);

        // random phases over document counts and idling mixes:
        // 1 and 0 the low extremes, 127 and 65 above the document range
        run_phase(7'd1,   83, 0,  PHASE_ITEMS, 1'b0);
        run_phase(7'd64,  0,  0,  PHASE_ITEMS, 1'b1);
        run_phase(7'd127, 0,  83, PHASE_ITEMS, 1'b0);
        run_phase(7'd0,   34, 34, PHASE_ITEMS, 1'b0);
        run_phase(7'd37,  0,  0,  PHASE_ITEMS, 1'b0);
        run_phase(7'd65,  83, 0,  PHASE_ITEMS, 1'b0);
        run_phase(7'd10,  0,  83, PHASE_ITEMS, 1'b0);
        run_phase(7'd64,  34, 34, PHASE_ITEMS, 1'b0);

        // wind down: stop offering, collect what is owed, then a quiet tail
        item_ch.valid <= 1'b0;
        drain_wait = 0;
        while (answers_due.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (answers_due.size() != 0)
        begin
            $error("%0d owed results never arrived", answers_due.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
